>>> design/bcc_pkg.sv
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared widths, types and constants of the barycentric coordinate pipeline.
// ----------------------------------------------------------------------------
package bcc_pkg;

  localparam int COORD_W   = 16;
  localparam int WFRAC_W   = 16;
  localparam int NCOORD    = 12;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int NDIFF     = 9;
  localparam int NDOT      = 5;
  localparam int NPROD     = 3 * NDOT;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int DOT_W     = PROD_W + 2;
  localparam int GRAM_W    = 2 * DOT_W;
  localparam int DET_W     = GRAM_W + 1;
  localparam int NUM_W     = DET_W + WFRAC_W;
  localparam int SQ_W      = NUM_W + 1;
  localparam int SU_W      = NUM_W + 2;
  localparam int WEIGHT_W  = 32;
  localparam int LIM_W     = 32;
  localparam int IN_W      = NCOORD * COORD_W;
  localparam int OUT_W     = 3 * WEIGHT_W;

  localparam logic [LIM_W-1:0]    LIM_RESET  = LIM_W'(4295);
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
  localparam logic [WEIGHT_W-1:0] WEIGHT_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

  typedef logic [NCOORD-1:0][COORD_W-1:0] bcc_coords_t;

  typedef struct packed {
    logic signed [DOT_W-1:0] d00;
    logic signed [DOT_W-1:0] d01;
    logic signed [DOT_W-1:0] d11;
    logic signed [DOT_W-1:0] d20;
    logic signed [DOT_W-1:0] d21;
  } bcc_dots_t;

  typedef struct packed {
    logic             ok;
    logic             neg_v;
    logic             neg_w;
    logic [DET_W-1:0] den;
    logic [DET_W-1:0] num_v;
    logic [DET_W-1:0] num_w;
  } bcc_div_in_t;

  typedef struct packed {
    logic             ok;
    logic             neg_v;
    logic             neg_w;
    logic [NUM_W-1:0] q_v;
    logic [NUM_W-1:0] q_w;
  } bcc_quo_t;

  typedef struct packed {
    logic                res_valid;
    logic [WEIGHT_W-1:0] w;
    logic [WEIGHT_W-1:0] v;
    logic [WEIGHT_W-1:0] u;
  } bcc_result_t;

endpackage

>>> design/bcc_front.sv
// ----------------------------------------------------------------------------
// bcc_front
// Edge vectors, partial products and the five dot products (three stages).
// ----------------------------------------------------------------------------
module bcc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  bcc_pkg::bcc_coords_t coords_i,
  output logic                valid_o,
  output bcc_pkg::bcc_dots_t  dots_o
);

  localparam int DOT_A [bcc_pkg::NDOT] = '{0, 0, 1, 2, 2};
  localparam int DOT_B [bcc_pkg::NDOT] = '{0, 1, 1, 0, 1};

  logic [2:0] valid_q;

  logic signed [bcc_pkg::DIFF_W-1:0] diff_d [bcc_pkg::NDIFF];
  logic signed [bcc_pkg::DIFF_W-1:0] diff_q [bcc_pkg::NDIFF];
  logic signed [bcc_pkg::PROD_W-1:0] prod_d [bcc_pkg::NPROD];
  logic signed [bcc_pkg::PROD_W-1:0] prod_q [bcc_pkg::NPROD];
  logic signed [bcc_pkg::DOT_W-1:0]  dot_d  [bcc_pkg::NDOT];
  logic signed [bcc_pkg::DOT_W-1:0]  dot_q  [bcc_pkg::NDOT];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        diff_d[3*k+i] = {coords_i[3*(k+1)+i][bcc_pkg::COORD_W-1], coords_i[3*(k+1)+i]}
                      - {coords_i[i][bcc_pkg::COORD_W-1], coords_i[i]};
      end
    end
  end

  always_comb begin
    for (int j = 0; j < bcc_pkg::NDOT; j++) begin
      for (int i = 0; i < 3; i++) begin
        prod_d[3*j+i] = diff_q[3*DOT_A[j]+i] * diff_q[3*DOT_B[j]+i];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < bcc_pkg::NDOT; j++) begin
      dot_d[j] = bcc_pkg::DOT_W'(prod_q[3*j]) + bcc_pkg::DOT_W'(prod_q[3*j+1])
               + bcc_pkg::DOT_W'(prod_q[3*j+2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      diff_q <= diff_d;
      prod_q <= prod_d;
      dot_q  <= dot_d;
    end
  end

  assign valid_o    = valid_q[2];
  assign dots_o.d00 = dot_q[0];
  assign dots_o.d01 = dot_q[1];
  assign dots_o.d11 = dot_q[2];
  assign dots_o.d20 = dot_q[3];
  assign dots_o.d21 = dot_q[4];

endmodule

>>> design/bcc_gram.sv
// ----------------------------------------------------------------------------
// bcc_gram
// Gram products, determinant and numerators, then magnitudes and the
// degenerate test (three stages).
// ----------------------------------------------------------------------------
module bcc_gram (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  bcc_pkg::bcc_dots_t           dots_i,
  input  logic [bcc_pkg::LIM_W-1:0]    limit_i,
  output logic                         valid_o,
  output bcc_pkg::bcc_div_in_t         div_o
);

  logic [2:0] valid_q;

  logic signed [bcc_pkg::GRAM_W-1:0] gp_d [6];
  logic signed [bcc_pkg::GRAM_W-1:0] gp_q [6];
  logic signed [bcc_pkg::DET_W-1:0]  det_d, det_q, nv_d, nv_q, nw_d, nw_q;
  logic [bcc_pkg::DET_W-1:0]         mag_d;
  bcc_pkg::bcc_div_in_t              div_d, div_q;

  always_comb begin
    gp_d[0] = $signed(dots_i.d00) * $signed(dots_i.d11);
    gp_d[1] = $signed(dots_i.d01) * $signed(dots_i.d01);
    gp_d[2] = $signed(dots_i.d11) * $signed(dots_i.d20);
    gp_d[3] = $signed(dots_i.d01) * $signed(dots_i.d21);
    gp_d[4] = $signed(dots_i.d00) * $signed(dots_i.d21);
    gp_d[5] = $signed(dots_i.d01) * $signed(dots_i.d20);
  end

  always_comb begin
    det_d = bcc_pkg::DET_W'(gp_q[0]) - bcc_pkg::DET_W'(gp_q[1]);
    nv_d  = bcc_pkg::DET_W'(gp_q[2]) - bcc_pkg::DET_W'(gp_q[3]);
    nw_d  = bcc_pkg::DET_W'(gp_q[4]) - bcc_pkg::DET_W'(gp_q[5]);
  end

  always_comb begin
    mag_d       = det_q[bcc_pkg::DET_W-1] ? -det_q : det_q;
    div_d.den   = mag_d;
    div_d.num_v = nv_q[bcc_pkg::DET_W-1] ? -nv_q : nv_q;
    div_d.num_w = nw_q[bcc_pkg::DET_W-1] ? -nw_q : nw_q;
    div_d.neg_v = nv_q[bcc_pkg::DET_W-1] ^ det_q[bcc_pkg::DET_W-1];
    div_d.neg_w = nw_q[bcc_pkg::DET_W-1] ^ det_q[bcc_pkg::DET_W-1];
    div_d.ok    = (det_q != '0) && (mag_d >= bcc_pkg::DET_W'(limit_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      gp_q  <= gp_d;
      det_q <= det_d;
      nv_q  <= nv_d;
      nw_q  <= nw_d;
      div_q <= div_d;
    end
  end

  assign valid_o = valid_q[2];
  assign div_o   = div_q;

endmodule

>>> design/bcc_div.sv
// ----------------------------------------------------------------------------
// bcc_div
// Pipelined restoring divider, one quotient bit per stage, two numerator
// lanes sharing one denominator.
// ----------------------------------------------------------------------------
module bcc_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  bcc_pkg::bcc_div_in_t div_i,
  output logic                 valid_o,
  output bcc_pkg::bcc_quo_t    quo_o
);

  localparam int NS = bcc_pkg::NUM_W;
  localparam int DW = bcc_pkg::DET_W;

  typedef struct packed {
    logic          ok;
    logic          neg_v;
    logic          neg_w;
    logic [DW-1:0] den;
    logic [DW-1:0] rem_v;
    logic [DW-1:0] rem_w;
    logic [NS-1:0] nq_v;
    logic [NS-1:0] nq_w;
  } stage_t;

  logic [NS-1:0] valid_q;
  stage_t        st_d [NS];
  stage_t        st_q [NS];

  // One restoring step: returns the new remainder above the shifted
  // numerator/quotient word.
  function automatic logic [DW+NS-1:0] div_step(input logic [DW-1:0] rem,
                                                input logic [NS-1:0] nq,
                                                input logic [DW-1:0] den);
    logic [DW:0] shifted;
    logic [DW:0] trial;
    shifted = {rem, nq[NS-1]};
    trial   = shifted - {1'b0, den};
    if (!trial[DW]) begin
      div_step = {trial[DW-1:0], nq[NS-2:0], 1'b1};
    end else begin
      div_step = {shifted[DW-1:0], nq[NS-2:0], 1'b0};
    end
  endfunction

  always_comb begin
    stage_t src;
    for (int k = 0; k < NS; k++) begin
      if (k == 0) begin
        src.ok    = div_i.ok;
        src.neg_v = div_i.neg_v;
        src.neg_w = div_i.neg_w;
        src.den   = div_i.den;
        src.rem_v = '0;
        src.rem_w = '0;
        src.nq_v  = {div_i.num_v, {bcc_pkg::WFRAC_W{1'b0}}};
        src.nq_w  = {div_i.num_w, {bcc_pkg::WFRAC_W{1'b0}}};
      end else begin
        src = st_q[k-1];
      end
      st_d[k] = src;
      {st_d[k].rem_v, st_d[k].nq_v} = div_step(src.rem_v, src.nq_v, src.den);
      {st_d[k].rem_w, st_d[k].nq_w} = div_step(src.rem_w, src.nq_w, src.den);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[NS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign valid_o     = valid_q[NS-1];
  assign quo_o.ok    = st_q[NS-1].ok;
  assign quo_o.neg_v = st_q[NS-1].neg_v;
  assign quo_o.neg_w = st_q[NS-1].neg_w;
  assign quo_o.q_v   = st_q[NS-1].nq_v;
  assign quo_o.q_w   = st_q[NS-1].nq_w;

endmodule

>>> design/bcc_out.sv
// ----------------------------------------------------------------------------
// bcc_out
// Quotient signs, u = one - v - w, saturation and the output register
// (three stages).
// ----------------------------------------------------------------------------
module bcc_out (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  bcc_pkg::bcc_quo_t    quo_i,
  output logic                 valid_o,
  output bcc_pkg::bcc_result_t res_o
);

  localparam logic signed [bcc_pkg::SU_W-1:0] ONE =
    bcc_pkg::SU_W'(1) << bcc_pkg::WFRAC_W;

  logic [2:0] valid_q;
  logic       ok1_q, ok2_q;

  logic signed [bcc_pkg::SQ_W-1:0] sqv_d, sqv_q, sqw_d, sqw_q, sqv2_q, sqw2_q;
  logic signed [bcc_pkg::SU_W-1:0] su_d, su_q;
  bcc_pkg::bcc_result_t            res_d, res_q;

  function automatic logic [bcc_pkg::WEIGHT_W-1:0] sat_w(
      input logic signed [bcc_pkg::SU_W-1:0] x);
    logic [bcc_pkg::SU_W-bcc_pkg::WEIGHT_W:0] top;
    top = x[bcc_pkg::SU_W-1:bcc_pkg::WEIGHT_W-1];
    if (top == '0 || top == '1) begin
      sat_w = x[bcc_pkg::WEIGHT_W-1:0];
    end else if (x[bcc_pkg::SU_W-1]) begin
      sat_w = bcc_pkg::WEIGHT_MIN;
    end else begin
      sat_w = bcc_pkg::WEIGHT_MAX;
    end
  endfunction

  always_comb begin
    sqv_d = quo_i.neg_v ? -$signed({1'b0, quo_i.q_v}) : $signed({1'b0, quo_i.q_v});
    sqw_d = quo_i.neg_w ? -$signed({1'b0, quo_i.q_w}) : $signed({1'b0, quo_i.q_w});
  end

  assign su_d = ONE - bcc_pkg::SU_W'(sqv_q) - bcc_pkg::SU_W'(sqw_q);

  always_comb begin
    res_d.res_valid = ok2_q;
    res_d.u         = ok2_q ? sat_w(su_q) : '0;
    res_d.v         = ok2_q ? sat_w(bcc_pkg::SU_W'(sqv2_q)) : '0;
    res_d.w         = ok2_q ? sat_w(bcc_pkg::SU_W'(sqw2_q)) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ok1_q  <= quo_i.ok;
      sqv_q  <= sqv_d;
      sqw_q  <= sqw_d;
      ok2_q  <= ok1_q;
      su_q   <= su_d;
      sqv2_q <= sqv_q;
      sqw2_q <= sqw_q;
      res_q  <= res_d;
    end
  end

  assign valid_o = valid_q[2];
  assign res_o   = res_q;

endmodule

>>> design/triangle_barycentric_coords.sv
// ----------------------------------------------------------------------------
// triangle_barycentric_coords
// Barycentric weights of a query point against a 3-D triangle, Q8.8 in,
// Q15.16 saturated weights out, with a degenerate-triangle test.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// s_axis    in         tdata: corners 0..2 x/y/z, query x/y/z, 16 bits each
// m_axis    out        tdata: weight_u, weight_v, weight_w; tuser: valid_res
// cfg       in         degenerate limit, 32 bits
//
// One transfer enters per cycle while the output does not stall; the depth of
// the pipeline is set mostly by the 89-step restoring divider.
// Reset empties the pipeline and loads the limit with 4295.
// While the output waits, the whole pipeline holds; a one-entry input skid
// register takes one more transfer, so tready never depends on m_axis_tready_i.
// ----------------------------------------------------------------------------
module triangle_barycentric_coords (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // corner0_x, corner0_y, corner0_z, corner1_x .. corner2_z, query_x .. query_z
  input  logic [bcc_pkg::IN_W-1:0]      s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // weight_u, weight_v, weight_w
  output logic [bcc_pkg::OUT_W-1:0]     m_axis_tdata_o,
  // valid_res
  output logic                          m_axis_tuser_o,
  input  logic                          cfg_we_i,
  input  logic [bcc_pkg::LIM_W-1:0]     cfg_wdata_i
);

  logic [bcc_pkg::LIM_W-1:0] limit_q;
  logic                      skid_full_q;
  logic [bcc_pkg::IN_W-1:0]  skid_data_q;
  logic                      pipe_en;
  logic                      pipe_valid;
  bcc_pkg::bcc_coords_t      pipe_coords;

  logic                      front_valid, gram_valid, div_valid, out_valid;
  bcc_pkg::bcc_dots_t        dots;
  bcc_pkg::bcc_div_in_t      div_in;
  bcc_pkg::bcc_quo_t         quo;
  bcc_pkg::bcc_result_t      res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= bcc_pkg::LIM_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  assign pipe_en         = !out_valid || m_axis_tready_i;
  assign s_axis_tready_o = !skid_full_q;
  assign pipe_valid      = skid_full_q || s_axis_tvalid_i;
  assign pipe_coords     = skid_full_q ? skid_data_q : s_axis_tdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_full_q <= 1'b0;
    end else if (pipe_en) begin
      skid_full_q <= 1'b0;
    end else if (s_axis_tvalid_i && !skid_full_q) begin
      skid_full_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!pipe_en && !skid_full_q) begin
      skid_data_q <= s_axis_tdata_i;
    end
  end

  bcc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (pipe_en),
    .valid_i  (pipe_valid),
    .coords_i (pipe_coords),
    .valid_o  (front_valid),
    .dots_o   (dots)
  );

  bcc_gram u_gram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (front_valid),
    .dots_i  (dots),
    .limit_i (limit_q),
    .valid_o (gram_valid),
    .div_o   (div_in)
  );

  bcc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (gram_valid),
    .div_i   (div_in),
    .valid_o (div_valid),
    .quo_o   (quo)
  );

  bcc_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (div_valid),
    .quo_i   (quo),
    .valid_o (out_valid),
    .res_o   (res)
  );

  assign m_axis_tvalid_o = out_valid;
  assign m_axis_tuser_o  = res.res_valid;
  assign m_axis_tdata_o  = {res.w, res.v, res.u};

  // A degenerate result carries all-zero weights.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("degenerate result with nonzero weights");

  // An input transfer taken during a stall must land in the skid register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && !pipe_en |=> skid_full_q)
    else $error("stalled input transfer not held in skid register");

  // The skid entry is only released when the pipeline advances.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_full_q && !pipe_en |=> skid_full_q && $stable(skid_data_q))
    else $error("skid entry lost during stall");

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for triangle_barycentric_coords. Coordinates are driven
// over the input stream and the weights are predicted with exact wide integer
// arithmetic. Every result is compared in order with its prediction. The bench
// covers directed corner cases, random triangles, random idle gaps on both
// sides, a long output stall and several degenerate-limit settings.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct {
    logic            res_valid;
    logic [31:0]     u;
    logic [31:0]     v;
    logic [31:0]     w;
  } weights_t;

  int errors = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    $display("MISMATCH %s: got %h, want %h", what, got, exp);
    errors++;
  endtask

  function automatic logic [31:0] sat32(input logic signed [255:0] a);
    if (a > 256'sd2147483647) return bcc_pkg::WEIGHT_MAX;
    if (a < -256'sd2147483648) return bcc_pkg::WEIGHT_MIN;
    return a[31:0];
  endfunction

  function automatic logic signed [255:0] quot(input logic signed [255:0] n,
                                               input logic signed [255:0] d);
    logic signed [255:0] an, ad, q;
    an = (n < 0) ? -n : n;
    ad = (d < 0) ? -d : d;
    q = (an <<< bcc_pkg::WFRAC_W) / ad;
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  class weight_board;
    weights_t pending[$];
    logic [31:0] limit;

    function void note_input(input bcc_pkg::bcc_coords_t c);
      logic signed [255:0] e0 [3], e1 [3], p [3];
      logic signed [255:0] d00, d01, d11, d20, d21, det, mag, qv, qw, qu;
      weights_t r;
      d00 = 0; d01 = 0; d11 = 0; d20 = 0; d21 = 0;
      for (int i = 0; i < 3; i++) begin
        e0[i] = $signed(c[3+i]) - $signed(c[i]);
        e1[i] = $signed(c[6+i]) - $signed(c[i]);
        p[i]  = $signed(c[9+i]) - $signed(c[i]);
        d00 += e0[i] * e0[i];
        d01 += e0[i] * e1[i];
        d11 += e1[i] * e1[i];
        d20 += p[i] * e0[i];
        d21 += p[i] * e1[i];
      end
      det = d00 * d11 - d01 * d01;
      mag = (det < 0) ? -det : det;
      r = '{1'b0, 32'd0, 32'd0, 32'd0};
      if (det != 0 && mag >= $signed({224'd0, limit})) begin
        qv = quot(d11 * d20 - d01 * d21, det);
        qw = quot(d00 * d21 - d01 * d20, det);
        qu = (256'sd1 <<< bcc_pkg::WFRAC_W) - qv - qw;
        r = '{1'b1, sat32(qu), sat32(qv), sat32(qw)};
      end
      pending.push_back(r);
    endfunction

    task check_result(input logic tuser, input logic [bcc_pkg::OUT_W-1:0] data);
      weights_t e;
      if (pending.size() == 0) begin
        report("result with no prediction waiting", 32'd0, 32'd0);
        return;
      end
      e = pending.pop_front();
      if (tuser !== e.res_valid) report("valid_res", {31'd0, tuser}, {31'd0, e.res_valid});
      if (data[31:0] !== e.u) report("weight_u", data[31:0], e.u);
      if (data[63:32] !== e.v) report("weight_v", data[63:32], e.v);
      if (data[95:64] !== e.w) report("weight_w", data[95:64], e.w);
    endtask
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic s_axis_tvalid_i = 0;
  logic s_axis_tready_o;
  logic [bcc_pkg::IN_W-1:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 0;
  logic [bcc_pkg::OUT_W-1:0] m_axis_tdata_o;
  logic m_axis_tuser_o;
  logic cfg_we_i = 0;
  logic [bcc_pkg::LIM_W-1:0] cfg_wdata_i = '0;

  weight_board board = new();
  bit hold_output = 0;
  int cycles = 0;

  always begin
    #6 clk_i = 1;
    #6 clk_i = 0;
  end

  triangle_barycentric_coords uut (.*);

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  always @(posedge clk_i) begin
    cycles++;
    if (m_axis_tvalid_o && m_axis_tready_i) board.check_result(m_axis_tuser_o, m_axis_tdata_o);
    if (cycles > 600000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_output) begin
        m_axis_tready_i <= 0;
      end else if (m_axis_tready_i) begin
        g = gap_length();
        if (g > 0) begin
          m_axis_tready_i <= 0;
          repeat (g) @(negedge clk_i);
          m_axis_tready_i <= 1;
        end
      end else begin
        m_axis_tready_i <= 1;
      end
    end
  end

  task automatic send(input bcc_pkg::bcc_coords_t c, input bit gaps);
    int g;
    g = gaps ? gap_length() : 0;
    if (g > 0) begin
      s_axis_tvalid_i <= 0;
      repeat (g) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1;
    s_axis_tdata_i <= c;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    board.note_input(c);
    @(negedge clk_i);
  endtask

  task automatic go_idle();
    s_axis_tvalid_i <= 0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (110) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [31:0] val);
    cfg_we_i <= 1;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 0;
    board.limit = val;
  endtask

  function automatic logic [15:0] rnd_coord(input int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 1023)) - 512);
      default: return 16'($signed($urandom_range(0, 31)) - 16);
    endcase
  endfunction

  function automatic bcc_pkg::bcc_coords_t rnd_item();
    bcc_pkg::bcc_coords_t c;
    int mode, kind;
    mode = $urandom_range(0, 2);
    kind = $urandom_range(0, 9);
    for (int i = 0; i < bcc_pkg::NCOORD; i++) c[i] = rnd_coord(mode);
    if (kind == 0) begin
      for (int i = 0; i < 3; i++) c[6+i] = c[3+i];
    end else if (kind == 1) begin
      for (int i = 0; i < 3; i++) c[6+i] = 16'(2 * $signed(c[3+i]) - $signed(c[i]));
    end else if (kind == 2) begin
      for (int i = 0; i < 3; i++) c[9+i] = c[$urandom_range(0, 2) * 3 + i];
    end
    return c;
  endfunction

  initial begin
    bcc_pkg::bcc_coords_t c;
    logic [31:0] limits [5];
    board.limit = bcc_pkg::LIM_RESET;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // Directed items: unit triangle, extremes, degenerate and outside points.
    c = '0; c[3] = 16'h0100; c[7] = 16'h0100; c[9] = 16'h0040; c[10] = 16'h0040;
    send(c, 0);
    c[9] = 16'h7fff; c[10] = 16'h8000; c[11] = 16'h7fff;
    send(c, 0);
    send('0, 0);
    for (int i = 0; i < bcc_pkg::NCOORD; i++) c[i] = 16'h8000;
    send(c, 0);
    for (int i = 0; i < bcc_pkg::NCOORD; i++) c[i] = (i % 2) ? 16'h7fff : 16'h8000;
    send(c, 0);
    c = '0; c[3] = 16'h7fff; c[7] = 16'h7fff; c[2] = 16'h8000;
    c[9] = 16'h8000; c[10] = 16'h8000; c[11] = 16'hffff;
    send(c, 0);
    c = '0; c[3] = 16'h0001; c[7] = 16'h0001; c[9] = 16'h0001;
    send(c, 0);
    c = '0; c[3] = 16'h0001; c[4] = 16'h0001; c[6] = 16'h0002; c[7] = 16'h0002;
    send(c, 0);
    c = '0; c[3] = 16'h0001; c[7] = 16'h0001; c[9] = 16'h7fff; c[10] = 16'h7fff;
    send(c, 0);
    for (int k = 0; k < 12; k++) send(rnd_item(), 0);

    // Long output stall while the sender keeps offering transfers.
    fork
      begin
        hold_output = 1;
        repeat (300) @(negedge clk_i);
        hold_output = 0;
      end
      for (int k = 0; k < 150; k++) send(rnd_item(), 0);
    join

    limits[0] = 32'd0;
    limits[1] = 32'hffffffff;
    limits[2] = 32'd1;
    limits[3] = 32'd65536;
    limits[4] = bcc_pkg::LIM_RESET;
    for (int ph = 0; ph < 5; ph++) begin
      go_idle();
      write_limit(limits[ph]);
      c = '0; c[3] = 16'h0001; c[7] = 16'h0001;
      send(c, 0);
      for (int k = 0; k < 200; k++) send(rnd_item(), ph != 2);
    end

    go_idle();
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
